// File: hw/rtl/spdpid_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the encoder speed loop.
// Holds the beat payload structs, command and register codes and the multiplier control struct.
package spdpid_pkg;

	localparam int GAIN_W = 24;   // stored gain width
	localparam int OP_W   = 34;   // widest PID operand: e - 2*p1 + p2
	localparam int ACC_W  = 62;   // drive plus three products, any GAIN_FRAC_BITS up to 30
	localparam int IDX_W  = 3;
	localparam int CFG_W  = 24;

	localparam int DEF_PWM_PERIOD     = 50000;
	localparam int DEF_GAIN_FRAC_BITS = 24;

	localparam logic [1:0] CMD_TICK    = 2'd0;
	localparam logic [1:0] CMD_SET_POS = 2'd1;
	localparam logic [1:0] CMD_START   = 2'd2;

	localparam logic [1:0] CLAMP_NONE = 2'd0;
	localparam logic [1:0] CLAMP_LOW  = 2'd1;
	localparam logic [1:0] CLAMP_HIGH = 2'd2;

	localparam logic [IDX_W-1:0] REG_TARGET     = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_PROP  = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_INTEG = 3'd2;
	localparam logic [IDX_W-1:0] REG_GAIN_DERIV = 3'd3;
	localparam logic [IDX_W-1:0] REG_REVERSE    = 3'd4;

	localparam logic signed [15:0]       RST_TARGET     = 16'sd5;
	localparam logic signed [GAIN_W-1:0] RST_GAIN_PROP  = 24'sd50332;
	localparam logic signed [GAIN_W-1:0] RST_GAIN_INTEG = 24'sd5033;
	localparam logic signed [GAIN_W-1:0] RST_GAIN_DERIV = 24'sd16777;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] count_value;
	} item_t;

	typedef struct packed {
		logic [15:0]        compare_value;
		logic signed [31:0] measured_speed;
		logic signed [31:0] accumulated_error;
		logic [1:0]         clamp_state;
	} result_t;

	// One multiply-accumulate pass: acc (+)= mcand * signed mplr.
	typedef struct packed {
		logic                    start;
		logic                    keep_acc;
		logic signed [ACC_W-1:0] acc_init;
		logic signed [ACC_W-1:0] mcand;
		logic [GAIN_W-1:0]       mplr;
	} mac_cmd_t;

endpackage

// File: hw/rtl/encoder_speed_pid_pwm.sv
`timescale 1ns / 1ps
// Encoder speed loop: incremental PID on the accumulated speed error, drive level to PWM compare.
// Depends on spdpid_pkg and the bit-serial multiply-accumulate unit spdpid_mac.
//
// One item is worked on at a time. A set position, start or unused command beat goes from
// acceptance straight to the emit state, which loads its result. A control tick passes from
// acceptance to its result beat in steps: the accepting edge registers the count change,
// then the saturating error sum and the PID operands are registered in turn, then four
// passes through the one shared bit-serial multiplier (integral, proportional and
// derivative terms, then the scaling of the clamped drive level by PWM_PERIOD), with a
// hand-over after each of the three PID passes, one step to clamp and start the scaling
// pass, one to take the compare value and one to load the result register. The
// next item can be taken the cycle after its result is loaded. The result register stands
// between the two sides, so a new item is taken while the previous result still waits;
// the block then holds before loading the next result until that one is taken.
// Configuration writes take effect at once and are expected only while no item is being
// worked on.
module encoder_speed_pid_pwm import spdpid_pkg::*; #(
	parameter int PWM_PERIOD     = DEF_PWM_PERIOD,
	parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  item_t            item,
	output logic             result_valid,
	input  logic             result_ready,
	output result_t          result,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	// Drive level is unsigned in [0, 1.0], one integer bit above the fraction.
	localparam int DRV_W = GAIN_FRAC_BITS + 1;
	localparam logic signed [ACC_W-1:0] FULL_SCALE = ACC_W'(1) <<< GAIN_FRAC_BITS;
	localparam logic [GAIN_W-1:0] PERIOD_MPLR = GAIN_W'(PWM_PERIOD);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_OPS,
		ST_MUL,
		ST_CLAMP,
		ST_SCALE,
		ST_EMIT
	} state_t;

	// Configuration registers.
	logic signed [15:0]       target_q;
	logic signed [GAIN_W-1:0] gain_prop_q;
	logic signed [GAIN_W-1:0] gain_integ_q;
	logic signed [GAIN_W-1:0] gain_deriv_q;
	logic                     reverse_q;

	// Loop state.
	state_t             state_q;
	logic [1:0]         phase_q;
	logic [31:0]        last_count_q;
	logic signed [31:0] err_sum_q;
	logic signed [31:0] prev_err_q;
	logic signed [31:0] prev_err_two_q;
	logic [DRV_W-1:0]   drive_q;
	logic [15:0]        held_compare_q;
	logic signed [31:0] speed_q;
	logic [1:0]         clamp_q;
	logic signed [OP_W-1:0] op_p_q;
	logic signed [OP_W-1:0] op_d_q;
	logic               out_valid_q;
	result_t            out_data_q;

	// Datapath nets.
	logic [31:0]             delta;
	logic signed [34:0]      sum_wide;
	logic signed [31:0]      sum_sat;
	logic signed [OP_W-1:0]  op_i;
	logic signed [OP_W-1:0]  op_p;
	logic signed [OP_W-1:0]  op_d;
	mac_cmd_t                mac_cmd;
	logic                    mac_done;
	logic signed [ACC_W-1:0] mac_acc;
	logic [DRV_W-1:0]        drive_next;
	logic [1:0]              clamp_next;
	logic                    accept;
	logic                    out_free;

	assign accept   = item_valid && item_ready;
	assign out_free = !out_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q     <= RST_TARGET;
			gain_prop_q  <= RST_GAIN_PROP;
			gain_integ_q <= RST_GAIN_INTEG;
			gain_deriv_q <= RST_GAIN_DERIV;
			reverse_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET:     target_q     <= cfg_data[15:0];
				REG_GAIN_PROP:  gain_prop_q  <= cfg_data;
				REG_GAIN_INTEG: gain_integ_q <= cfg_data;
				REG_GAIN_DERIV: gain_deriv_q <= cfg_data;
				REG_REVERSE:    reverse_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The count change wraps like a 32-bit counter; reverse swaps the operands.
	assign delta = reverse_q ? (last_count_q - item.count_value)
	                         : (item.count_value - last_count_q);

	// Target minus speed is exact; the new sum saturates to 32 bits.
	always_comb begin
		sum_wide = 35'(err_sum_q) + 35'(target_q) - 35'(speed_q);
		if (sum_wide > 35'sh0_7FFF_FFFF) begin
			sum_sat = 32'sh7FFF_FFFF;
		end else if (sum_wide < -35'sh0_8000_0000) begin
			sum_sat = 32'sh8000_0000;
		end else begin
			sum_sat = sum_wide[31:0];
		end
	end

	assign op_i = OP_W'(err_sum_q);
	assign op_p = OP_W'(err_sum_q) - OP_W'(prev_err_q);
	assign op_d = OP_W'(err_sum_q) - (OP_W'(prev_err_q) <<< 1) + OP_W'(prev_err_two_q);

	// The accumulator holds drive + increment after the three PID passes.
	always_comb begin
		if (mac_acc < 0) begin
			drive_next = '0;
			clamp_next = CLAMP_LOW;
		end else if (mac_acc > FULL_SCALE) begin
			drive_next = FULL_SCALE[DRV_W-1:0];
			clamp_next = CLAMP_HIGH;
		end else begin
			drive_next = mac_acc[DRV_W-1:0];
			clamp_next = CLAMP_NONE;
		end
	end

	// Multiplier passes: Ki*e onto the drive level, then Kp and Kd terms, then scaling.
	always_comb begin
		mac_cmd          = '0;
		mac_cmd.acc_init = ACC_W'(drive_q);
		case (state_q)
			ST_OPS: begin
				mac_cmd.start = 1'b1;
				mac_cmd.mcand = ACC_W'(op_i);
				mac_cmd.mplr  = gain_integ_q;
			end
			ST_MUL: begin
				mac_cmd.keep_acc = 1'b1;
				if (mac_done && phase_q == 2'd0) begin
					mac_cmd.start = 1'b1;
					mac_cmd.mcand = ACC_W'(op_p_q);
					mac_cmd.mplr  = gain_prop_q;
				end else if (mac_done && phase_q == 2'd1) begin
					mac_cmd.start = 1'b1;
					mac_cmd.mcand = ACC_W'(op_d_q);
					mac_cmd.mplr  = gain_deriv_q;
				end
			end
			ST_CLAMP: begin
				mac_cmd.start    = 1'b1;
				mac_cmd.acc_init = '0;
				mac_cmd.mcand    = ACC_W'(drive_next);
				mac_cmd.mplr     = PERIOD_MPLR;
			end
			default: ;
		endcase
	end

	spdpid_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.done   (mac_done),
		.acc    (mac_acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			phase_q        <= '0;
			last_count_q   <= '0;
			err_sum_q      <= '0;
			prev_err_q     <= '0;
			prev_err_two_q <= '0;
			drive_q        <= '0;
			held_compare_q <= '0;
			speed_q        <= '0;
			clamp_q        <= CLAMP_NONE;
			op_p_q         <= '0;
			op_d_q         <= '0;
			out_valid_q    <= 1'b0;
			out_data_q     <= '0;
		end else begin
			// The result payload is loaded together with its valid.
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q                  <= 1'b1;
				out_data_q.compare_value     <= held_compare_q;
				out_data_q.measured_speed    <= speed_q;
				out_data_q.accumulated_error <= err_sum_q;
				out_data_q.clamp_state       <= clamp_q;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						clamp_q <= CLAMP_NONE;
						case (item.command)
							CMD_TICK: begin
								speed_q      <= delta;
								last_count_q <= item.count_value;
								state_q      <= ST_SUM;
							end
							CMD_SET_POS: begin
								speed_q      <= '0;
								last_count_q <= item.count_value;
								err_sum_q    <= '0;
								state_q      <= ST_EMIT;
							end
							CMD_START: begin
								speed_q   <= '0;
								err_sum_q <= '0;
								state_q   <= ST_EMIT;
							end
							default: begin
								speed_q <= '0;
								state_q <= ST_EMIT;
							end
						endcase
					end
				end
				ST_SUM: begin
					err_sum_q <= sum_sat;
					state_q   <= ST_OPS;
				end
				ST_OPS: begin
					op_p_q         <= op_p;
					op_d_q         <= op_d;
					prev_err_two_q <= prev_err_q;
					prev_err_q     <= err_sum_q;
					phase_q        <= '0;
					state_q        <= ST_MUL;
				end
				ST_MUL: begin
					if (mac_done) begin
						phase_q <= phase_q + 1'b1;
						if (phase_q == 2'd2) begin
							state_q <= ST_CLAMP;
						end
					end
				end
				ST_CLAMP: begin
					drive_q <= drive_next;
					clamp_q <= clamp_next;
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					if (mac_done) begin
						held_compare_q <= mac_acc[GAIN_FRAC_BITS +: 16];
						state_q        <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_data_q;

endmodule

// File: hw/rtl/spdpid_mac.sv
`timescale 1ns / 1ps
// Bit-serial multiply-accumulate unit: one multiplier bit per cycle, LSB first.
// Depends on spdpid_pkg for the command struct and widths.
module spdpid_mac import spdpid_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_cmd_t                cmd,
	output logic                    done,
	output logic signed [ACC_W-1:0] acc
);

	localparam int CNT_W = $clog2(GAIN_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(GAIN_W - 1);

	logic                    busy_q;
	logic                    done_q;
	logic [CNT_W-1:0]        step_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] mcand_q;
	logic [GAIN_W-1:0]       mplr_q;
	logic signed [ACC_W-1:0] addend;

	// The top multiplier bit carries negative weight.
	always_comb begin
		if (!mplr_q[0]) begin
			addend = '0;
		end else if (step_q == LAST_STEP) begin
			addend = -mcand_q;
		end else begin
			addend = mcand_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			if (!cmd.keep_acc) begin
				acc_q <= cmd.acc_init;
			end
			mcand_q <= cmd.mcand;
			mplr_q  <= cmd.mplr;
		end else if (busy_q) begin
			acc_q   <= acc_q + addend;
			mcand_q <= mcand_q <<< 1;
			mplr_q  <= mplr_q >> 1;
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

endmodule

// File: test/spdpid_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the encoder speed loop testbench: a bit-exact predictor of the PID loop.
// Depends on spdpid_pkg for the beat structs, command, clamp and register codes.
package spdpid_tb_pkg;
	import spdpid_pkg::*;

	localparam logic [1:0]       CMD_UNUSED = 2'd3;
	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

	localparam longint ERR_MAX    = 64'sd2147483647;
	localparam longint ERR_MIN    = -64'sd2147483648;
	localparam longint DRIVE_FULL = 64'sd1 <<< DEF_GAIN_FRAC_BITS;

	class speed_loop_scoreboard;
		// Mirror of the configuration registers.
		logic signed [15:0]       target;
		logic signed [GAIN_W-1:0] kp;
		logic signed [GAIN_W-1:0] ki;
		logic signed [GAIN_W-1:0] kd;
		logic                     rev;
		// Mirror of the loop state.
		logic [31:0] last_cnt;
		int          err_sum;
		int          err_prev;
		int          err_prev_two;
		longint      drive;
		logic [15:0] held_cmp;
		result_t     owed_results[$];
		int          errors;
		int          checked;

		function new();
			target       = RST_TARGET;
			kp           = RST_GAIN_PROP;
			ki           = RST_GAIN_INTEG;
			kd           = RST_GAIN_DERIV;
			rev          = 1'b0;
			last_cnt     = '0;
			err_sum      = 0;
			err_prev     = 0;
			err_prev_two = 0;
			drive        = 0;
			held_cmp     = '0;
			errors       = 0;
			checked      = 0;
		endfunction

		function int pending();
			return owed_results.size();
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] d);
			case (idx)
				REG_TARGET:     target = d[15:0];
				REG_GAIN_PROP:  kp = d;
				REG_GAIN_INTEG: ki = d;
				REG_GAIN_DERIV: kd = d;
				REG_REVERSE:    rev = d[0];
				default: ;
			endcase
		endfunction

		// Advances the loop by one accepted input beat and queues the answer it owes.
		function void note_item(item_t it);
			logic [31:0] delta;
			longint      speed;
			longint      sum;
			longint      e;
			longint      inc;
			longint      d;
			result_t     r;
			r = '0;
			case (it.command)
				CMD_TICK: begin
					delta = it.count_value - last_cnt;
					if (rev)
						delta = -delta;
					last_cnt = it.count_value;
					speed = longint'($signed(delta));
					sum = longint'(err_sum) + (longint'(target) - speed);
					if (sum > ERR_MAX)
						sum = ERR_MAX;
					if (sum < ERR_MIN)
						sum = ERR_MIN;
					err_sum = int'(sum);
					e = err_sum;
					inc = e * longint'(ki)
						+ (e - longint'(err_prev)) * longint'(kp)
						+ (e - 2 * longint'(err_prev) + longint'(err_prev_two)) * longint'(kd);
					err_prev_two = err_prev;
					err_prev = err_sum;
					d = drive + inc;
					r.clamp_state = CLAMP_NONE;
					if (d < 0) begin
						d = 0;
						r.clamp_state = CLAMP_LOW;
					end else if (d > DRIVE_FULL) begin
						d = DRIVE_FULL;
						r.clamp_state = CLAMP_HIGH;
					end
					drive = d;
					held_cmp = 16'((d * longint'(DEF_PWM_PERIOD)) >>> DEF_GAIN_FRAC_BITS);
					r.measured_speed = delta;
				end
				CMD_SET_POS: begin
					last_cnt = it.count_value;
					err_sum = 0;
				end
				CMD_START: begin
					err_sum = 0;
				end
				default: ;
			endcase
			r.compare_value = held_cmp;
			r.accumulated_error = err_sum;
			owed_results.push_back(r);
		endfunction

		task report(string what);
			$display("mismatch at result %0d: %s", checked, what);
			errors++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (owed_results.size() == 0) begin
				report($sformatf("result beat %h with nothing owed", got));
				return;
			end
			want = owed_results.pop_front();
			if (got.compare_value !== want.compare_value)
				report($sformatf("compare_value %0d, want %0d",
					got.compare_value, want.compare_value));
			if (got.measured_speed !== want.measured_speed)
				report($sformatf("measured_speed %0d, want %0d",
					got.measured_speed, want.measured_speed));
			if (got.accumulated_error !== want.accumulated_error)
				report($sformatf("accumulated_error %0d, want %0d",
					got.accumulated_error, want.accumulated_error));
			if (got.clamp_state !== want.clamp_state)
				report($sformatf("clamp_state %0d, want %0d",
					got.clamp_state, want.clamp_state));
			checked++;
		endtask
	endclass

endpackage

// File: test/tb_encoder_speed_pid_pwm.sv
`timescale 1ns / 1ps
// Self-checking testbench of encoder_speed_pid_pwm: directed corner beats, then random phases.
// Depends on spdpid_pkg and on the scoreboard in spdpid_tb_pkg.
module tb_encoder_speed_pid_pwm;
	import spdpid_pkg::*;
	import spdpid_tb_pkg::*;

	localparam int RANDOM_ITEMS  = 1150;
	localparam int PHASES        = 10;
	// Time given to a control tick to finish, with margin.
	localparam int SETTLE_CYCLES = 120;
	// Longest honest stretch without a beat is a tick plus a long stall and gap.
	localparam int STALL_LIMIT   = 2000;

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_ready;
	item_t            item;
	logic             result_valid;
	logic             result_ready;
	result_t          result;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	speed_loop_scoreboard sb;
	bit                   calm;
	int                   idle_cycles;

	encoder_speed_pid_pwm u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Idle lengths: mostly none or short, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	function automatic logic [CFG_W-1:0] gain_edge();
		return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
	endfunction

	// The receiver side. In a calm phase it never stalls; otherwise it alternates
	// runs of ready with stalls, so that back pressure lands on every phase of a tick.
	initial begin
		int run;
		logic rdy;
		result_ready = 1'b0;
		run = 0;
		forever begin
			@(negedge clk);
			if (calm) begin
				result_ready = 1'b1;
			end else begin
				if (run == 0) begin
					rdy = ($urandom_range(0, 99) < 65);
					run = rdy ? $urandom_range(1, 12) : idle_len() + 1;
					result_ready = rdy;
				end
				run--;
			end
		end
	end

	// Every beat is seen at the rising edge. A result beat is checked before the input
	// beat of the same edge is noted, although the queue order makes either safe.
	initial begin
		bit moved;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			moved = 1'b0;
			if (arst_n) begin
				if (result_valid && result_ready) begin
					sb.check_result(result);
					moved = 1'b1;
				end
				if (item_valid && item_ready) begin
					sb.note_item(item);
					moved = 1'b1;
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
		end
	end

	// The watchdog ends a run that has stopped moving.
	initial begin
		do @(posedge clk); while (idle_cycles < STALL_LIMIT);
		$display("encoder_speed_pid_pwm regression: fail");
		$finish;
	end

	// Offers one input beat and holds it until it is taken. When the next beat follows
	// without a gap, valid simply stays high and only the payload changes.
	task automatic push_item(logic [1:0] cmd, logic [31:0] cnt);
		item_t it;
		int gap;
		it.command = cmd;
		it.count_value = cnt;
		@(negedge clk);
		item_valid = 1'b1;
		item = it;
		do @(posedge clk); while (!item_ready);
		gap = calm ? 0 : idle_len();
		if (gap > 0) begin
			@(negedge clk);
			item_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Registers may only change while the block is idle, so the sender stops, every
	// owed result is collected and the block is given time to finish.
	task automatic settle();
		@(negedge clk);
		item_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Back-to-back writes keep the enable high; cfg_close lowers it afterwards.
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] d);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		sb.set_reg(idx, d);
	endtask

	task automatic cfg_close();
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Four flavors of setting: the reset values, small positive gains that keep the
	// drive level inside its range, the extremes of every register, and raw random
	// words with junk in the bits above each register's width.
	task automatic program_phase(int kind);
		logic [CFG_W-1:0] t;
		logic [CFG_W-1:0] p;
		logic [CFG_W-1:0] i;
		logic [CFG_W-1:0] dv;
		logic [CFG_W-1:0] rv;
		case (kind)
			0: begin
				t = 24'(RST_TARGET);
				p = RST_GAIN_PROP;
				i = RST_GAIN_INTEG;
				dv = RST_GAIN_DERIV;
				rv = '0;
			end
			1: begin
				t = 24'(int'($urandom_range(0, 40)) - 20);
				p = 24'($urandom_range(0, 1 << 17));
				i = 24'($urandom_range(0, 1 << 13));
				dv = 24'($urandom_range(0, 1 << 16));
				rv = 24'($urandom);
			end
			2: begin
				t = $urandom_range(0, 1) ? 24'h007FFF : 24'hFF8000;
				p = gain_edge();
				i = gain_edge();
				dv = gain_edge();
				rv = 24'($urandom);
			end
			default: begin
				t = 24'($urandom);
				p = 24'($urandom);
				i = 24'($urandom);
				dv = 24'($urandom);
				rv = 24'($urandom);
			end
		endcase
		write_reg(REG_TARGET, t);
		write_reg(REG_GAIN_PROP, p);
		write_reg(REG_GAIN_INTEG, i);
		write_reg(REG_GAIN_DERIV, dv);
		write_reg(REG_REVERSE, rv);
		if (kind == 3)
			write_reg(REG_UNUSED, 24'($urandom));
		cfg_close();
	endtask

	// Random traffic. Most beats are ticks whose count moves by about the wanted
	// speed, so the loop behaves like a real motor and the drive level wanders inside
	// its range. The rest are wild counts (wrap and saturation), position loads,
	// starts and the unused command. Unused-command beats do not count toward n.
	task automatic run_random(int n);
		int counted;
		int r;
		int step;
		logic [1:0] cmd;
		logic [31:0] cnt;
		counted = 0;
		while (counted < n) begin
			r = $urandom_range(0, 99);
			if (r < 78) begin
				cmd = CMD_TICK;
				step = sb.rev ? -int'(sb.target) : int'(sb.target);
				if ($urandom_range(0, 99) < 85)
					step += int'($urandom_range(0, 6)) - 3;
				else
					step += int'($urandom_range(0, 2000)) - 1000;
				cnt = sb.last_cnt + step;
			end else if (r < 84) begin
				cmd = CMD_TICK;
				cnt = $urandom;
			end else if (r < 90) begin
				cmd = CMD_SET_POS;
				cnt = $urandom_range(0, 1) ? $urandom : sb.last_cnt + $urandom_range(0, 64);
			end else if (r < 95) begin
				cmd = CMD_START;
				cnt = $urandom;
			end else begin
				cmd = CMD_UNUSED;
				cnt = $urandom;
			end
			push_item(cmd, cnt);
			if (cmd != CMD_UNUSED)
				counted++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		sb = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, under the reset values: plain ticks, a count going negative, the
		// unused command, then the count change wrapping at the 32-bit boundary. Two
		// wraps downward push the error sum into positive saturation, and after a
		// start two large forward steps drive it into negative saturation.
		push_item(CMD_TICK, 32'd0);
		push_item(CMD_TICK, 32'd5);
		push_item(CMD_TICK, 32'hFFFF_FFFF);
		push_item(CMD_UNUSED, $urandom);
		push_item(CMD_SET_POS, 32'd0);
		push_item(CMD_TICK, 32'h8000_0000);
		push_item(CMD_TICK, 32'd0);
		push_item(CMD_START, $urandom);
		push_item(CMD_TICK, 32'h7FFF_FFFF);
		push_item(CMD_TICK, 32'hFFFF_FFFE);
		push_item(CMD_SET_POS, 32'h7FFF_FFFF);
		push_item(CMD_TICK, 32'h8000_0000);
		settle();

		// Directed bounds: with only an integral gain of one quarter, an error of 4
		// lands the drive exactly on full scale and an error of -4 brings it back
		// exactly to zero, neither of which counts as clamped. The first tick clamps
		// low and the third clamps high.
		write_reg(REG_TARGET, 24'd4);
		write_reg(REG_GAIN_PROP, 24'd0);
		write_reg(REG_GAIN_INTEG, 24'h40_0000);
		write_reg(REG_GAIN_DERIV, 24'd0);
		write_reg(REG_REVERSE, 24'd0);
		cfg_close();
		push_item(CMD_SET_POS, 32'd0);
		push_item(CMD_TICK, 32'd100000);
		push_item(CMD_START, 32'd0);
		push_item(CMD_TICK, 32'd100000);
		push_item(CMD_TICK, 32'd100000);
		push_item(CMD_START, $urandom);
		push_item(CMD_TICK, 32'd100008);
		settle();

		// Directed reverse: the most negative target written with junk above bit 15,
		// reverse written with junk above bit 0, and a change of exactly 2^31 whose
		// negation wraps onto itself.
		write_reg(REG_TARGET, 24'hAB_8000);
		write_reg(REG_REVERSE, 24'hFF_FFFF);
		cfg_close();
		push_item(CMD_SET_POS, 32'd0);
		push_item(CMD_TICK, 32'h8000_0000);
		push_item(CMD_TICK, 32'h7FFF_FFF0);
		settle();

		// Random phases, each under its own setting; every third one runs without
		// any idling on either side.
		for (int ph = 0; ph < PHASES; ph++) begin
			program_phase(ph % 4);
			calm = (ph % 3 == 2);
			run_random(RANDOM_ITEMS / PHASES);
			settle();
			calm = 1'b0;
		end

		if (sb.errors == 0)
			$display("encoder_speed_pid_pwm regression: pass");
		else
			$display("encoder_speed_pid_pwm regression: fail");
		$finish;
	end

endmodule
